### rtl/serial_command_frame_deframer_top_defines.svh
// assertion macros for the serial command frame deframer
// used by the top level only, needs aclk and aresetn in scope
`ifndef SERIAL_COMMAND_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scfd_pkg.sv
// shared types and constants of the serial command frame deframer
// no dependencies
`timescale 1ns / 1ps

package scfd_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int POS_W       = 3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_HDR = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_SYNC_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] sync_third;
    } sync_cfg_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [3:0]  payload_len;
        logic [63:0] payload_bytes;
    } scfd_result_t;

endpackage

### rtl/scfd_parser.sv
// header hunt, length check and payload collection for the frame deframer
// depends on scfd_pkg
`timescale 1ns / 1ps

module scfd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    input  scfd_pkg::sync_cfg_t   sync_cfg,
    output logic                  res_valid,
    output scfd_pkg::scfd_result_t res
);
    import scfd_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_HUNT3 = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [3:0] bytes_left_reg, bytes_left_next;
    logic [3:0] frame_length_reg, frame_length_next;
    logic [7:0] store_reg [MAX_PAYLOAD];

    logic [3:0]       pos_full;
    logic [POS_W-1:0] pos;
    logic             store_we;
    logic [63:0]      packed_bytes;

    assign pos_full = frame_length_reg - bytes_left_reg;
    assign pos      = pos_full[POS_W-1:0];

    // final byte is not in the store yet, so splice it in
    always_comb begin
        packed_bytes = '0;
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            if (4'(i) < frame_length_reg) begin
                if (POS_W'(i) == pos) begin
                    packed_bytes[8*i +: 8] = rx_byte;
                end else begin
                    packed_bytes[8*i +: 8] = store_reg[i];
                end
            end
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        frame_length_next = frame_length_reg;
        store_we          = 1'b0;
        res_valid         = 1'b0;
        res               = '{frame_status: ST_OK, payload_len: 4'd0, payload_bytes: 64'd0};
        if (byte_accept) begin
            unique case (phase_reg)
                PH_HUNT2: begin
                    if (rx_byte != sync_cfg.sync_second) begin
                        res_valid         = 1'b1;
                        res.frame_status  = ST_HDR;
                        phase_next        = PH_HUNT1;
                        bytes_left_next   = 4'd0;
                        frame_length_next = 4'd0;
                    end else begin
                        phase_next = PH_HUNT3;
                    end
                end
                PH_HUNT3: begin
                    if (rx_byte != sync_cfg.sync_third) begin
                        res_valid         = 1'b1;
                        res.frame_status  = ST_HDR;
                        phase_next        = PH_HUNT1;
                        bytes_left_next   = 4'd0;
                        frame_length_next = 4'd0;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (rx_byte == 8'd0 || rx_byte > 8'(MAX_PAYLOAD)) begin
                        res_valid         = 1'b1;
                        res.frame_status  = ST_LEN;
                        phase_next        = PH_HUNT1;
                        bytes_left_next   = 4'd0;
                        frame_length_next = 4'd0;
                    end else begin
                        phase_next        = PH_DATA;
                        bytes_left_next   = rx_byte[3:0];
                        frame_length_next = rx_byte[3:0];
                    end
                end
                PH_DATA: begin
                    store_we        = 1'b1;
                    bytes_left_next = bytes_left_reg - 4'd1;
                    if (bytes_left_reg == 4'd1) begin
                        res_valid         = 1'b1;
                        res.frame_status  = ST_OK;
                        res.payload_len   = frame_length_reg;
                        res.payload_bytes = packed_bytes;
                        phase_next        = PH_HUNT1;
                    end
                end
                // unused codes behave as hunting the first header byte
                default: begin
                    if (rx_byte != sync_cfg.sync_first) begin
                        res_valid         = 1'b1;
                        res.frame_status  = ST_HDR;
                        phase_next        = PH_HUNT1;
                        bytes_left_next   = 4'd0;
                        frame_length_next = 4'd0;
                    end else begin
                        phase_next = PH_HUNT2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT1;
            bytes_left_reg   <= 4'd0;
            frame_length_reg <= 4'd0;
        end else begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            frame_length_reg <= frame_length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[pos] <= rx_byte;
        end
    end

endmodule

### rtl/serial_command_frame_deframer_top.sv
// Serial command frame deframer, top level.
// Output: the result of a frame-ending or frame-breaking byte is registered behind m_tvalid.
// Throughput: one byte per cycle while the skid stage is empty; the output register plus
// a skid stage keep s_tready high while a single result waits on m_tready.
// Reset: synchronous active-low aresetn; hunting state, sync bytes back to ff 5a a5.
// depends on scfd_pkg, scfd_parser and serial_command_frame_deframer_top_defines.svh
`timescale 1ns / 1ps
`include "serial_command_frame_deframer_top_defines.svh"

module serial_command_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] payload_len, [67:4] payload_bytes, [71:68] zero
    output logic [1:0]  m_tuser,   // [1:0] frame_status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import scfd_pkg::*;

    sync_cfg_t    sync_cfg_reg;
    scfd_result_t out_reg, skid_reg, new_res;
    logic         out_valid_reg, skid_valid_reg;
    logic         new_valid, byte_accept, pop;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !skid_valid_reg;
    assign byte_accept = s_tvalid && s_tready;
    assign pop         = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_cfg_reg <= '{sync_first: 8'hff, sync_second: 8'h5a, sync_third: 8'ha5};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  sync_cfg_reg.sync_first  <= cfg_data;
                REG_SYNC_SECOND: sync_cfg_reg.sync_second <= cfg_data;
                REG_SYNC_THIRD:  sync_cfg_reg.sync_third  <= cfg_data;
                default: ;
            endcase
        end
    end

    scfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .sync_cfg    (sync_cfg_reg),
        .res_valid   (new_valid),
        .res         (new_res)
    );

    // output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (new_valid) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (new_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg <= new_res;
            end else begin
                skid_reg <= new_res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.frame_status;
    assign m_tdata  = {4'd0, out_reg.payload_bytes, out_reg.payload_len};

    `SCFD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid stage holds a transaction while the output register is empty")
    `SCFD_ASSERT_NEXT(a_skid_refills, skid_valid_reg && m_tready, m_tvalid,
        "skid transaction lost when the output register drained")
    `SCFD_ASSERT_NOW(a_ok_len_range, m_tvalid && m_tuser == ST_OK,
        m_tdata[3:0] != 4'd0 && m_tdata[3:0] <= 4'(MAX_PAYLOAD),
        "completed frame with a length out of range")
    `SCFD_ASSERT_NOW(a_err_zero_fields, m_tvalid && m_tuser != ST_OK,
        m_tdata[3:0] == 4'd0 && m_tdata[67:4] == 64'd0,
        "error transaction carries a length or payload")

endmodule

### test/tb.sv
// self-checking testbench for serial_command_frame_deframer_top
// drives byte streams and register writes, predicts each result in-line
// depends on scfd_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb;
    import scfd_pkg::*;

    localparam int LIMIT         = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam int IDLE_PCT      = 8;

    // index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT1, PH_HUNT2, PH_HUNT3, PH_LEN, PH_DATA
    } parse_phase_t;

    typedef enum logic [2:0] {
        ACT_BYTE, ACT_REG, ACT_SETTLE, ACT_CALM, ACT_HOLD
    } act_kind_t;

    typedef struct {
        act_kind_t  kind;
        logic [1:0] index;
        logic [7:0] value;
    } stim_act_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // stimulus plan and expected frames
    stim_act_t    stim_q[$];
    scfd_result_t pending_frames[$];

    // predictor copy of the parser
    sync_cfg_t    sync_regs;
    parse_phase_t phase;
    logic [3:0]   bytes_left;
    logic [3:0]   frame_len;
    logic [7:0]   payload_mem [MAX_PAYLOAD];

    // sync bytes the stimulus builds headers from
    logic [7:0]   plan_sync [3];

    bit started, calm, hold_req, byte_taken, reg_taken;
    int settle_cnt, hold_cnt, cycles, fails;
    int n_bytes, n_frames, n_hdr_errs, n_len_errs, n_regs;

    serial_command_frame_deframer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic deframe_byte(input logic [7:0] b);
        scfd_result_t res;
        logic         emit_now;
        logic         hdr_bad;
        logic [2:0]   pos;
        res      = '0;
        emit_now = 1'b0;
        hdr_bad  = 1'b0;
        case (phase)
            PH_HUNT2: begin
                if (b != sync_regs.sync_second) hdr_bad = 1'b1;
                else phase = PH_HUNT3;
            end
            PH_HUNT3: begin
                if (b != sync_regs.sync_third) hdr_bad = 1'b1;
                else phase = PH_LEN;
            end
            PH_LEN: begin
                if (b == 8'd0 || b > MAX_PAYLOAD) begin
                    phase      = PH_HUNT1;
                    bytes_left = '0;
                    frame_len  = '0;
                    res.frame_status = ST_LEN;
                    emit_now   = 1'b1;
                    n_len_errs++;
                end else begin
                    frame_len  = b[3:0];
                    bytes_left = b[3:0];
                    phase      = PH_DATA;
                end
            end
            PH_DATA: begin
                pos = 3'(frame_len - bytes_left);
                payload_mem[pos] = b;
                bytes_left = bytes_left - 4'd1;
                if (bytes_left == 4'd0) begin
                    for (int i = 0; i < MAX_PAYLOAD; i++)
                        if (i < frame_len) res.payload_bytes[8*i +: 8] = payload_mem[i];
                    res.frame_status = ST_OK;
                    res.payload_len  = frame_len;
                    emit_now = 1'b1;
                    phase    = PH_HUNT1;
                    n_frames++;
                end
            end
            default: begin
                if (b != sync_regs.sync_first) hdr_bad = 1'b1;
                else phase = PH_HUNT2;
            end
        endcase
        // the offending byte is swallowed, hunting restarts on the next one
        if (hdr_bad) begin
            phase      = PH_HUNT1;
            bytes_left = '0;
            frame_len  = '0;
            res.frame_status = ST_HDR;
            emit_now   = 1'b1;
            n_hdr_errs++;
        end
        if (emit_now) pending_frames.push_back(res);
    endtask

    task automatic add_byte(input logic [7:0] b);
        stim_q.push_back('{ACT_BYTE, REG_SYNC_FIRST, b});
    endtask

    task automatic add_ctrl(input act_kind_t k, input logic [1:0] idx, input logic [7:0] v);
        stim_q.push_back('{k, idx, v});
    endtask

    task automatic add_sync(input logic [7:0] f, input logic [7:0] s, input logic [7:0] t);
        add_ctrl(ACT_SETTLE, REG_SYNC_FIRST, 8'd0);
        add_ctrl(ACT_REG, REG_SYNC_FIRST, f);
        add_ctrl(ACT_REG, REG_SYNC_SECOND, s);
        add_ctrl(ACT_REG, REG_SYNC_THIRD, t);
        plan_sync[0] = f;
        plan_sync[1] = s;
        plan_sync[2] = t;
    endtask

    // bad_at 0..2 corrupts that header byte, -1 keeps the header intact
    task automatic add_frame(input int bad_at, input logic [7:0] len);
        for (int i = 0; i < 3; i++) begin
            if (i == bad_at) begin
                add_byte(plan_sync[i] ^ 8'($urandom_range(1, 255)));
                return;
            end
            add_byte(plan_sync[i]);
        end
        add_byte(len);
        if (len == 8'd0 || len > MAX_PAYLOAD) return;
        for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_traffic(input int n);
        int start_sz;
        int pick;
        start_sz = stim_q.size();
        while (stim_q.size() - start_sz < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                add_frame(-1, 8'($urandom_range(1, MAX_PAYLOAD)));
            else if (pick < 83)
                add_frame($urandom_range(0, 2), 8'd1);
            else if (pick < 90)
                add_frame(-1, $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(9, 255)));
            else
                add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // input acceptance, register writes and result checking
    always @(posedge aclk) begin
        scfd_result_t exp_res;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_frames.size() == 0) begin
                    $error("unexpected result: status %0h len %0h data %0h",
                           m_tuser, m_tdata[3:0], m_tdata[67:4]);
                    fails++;
                end else begin
                    exp_res = pending_frames.pop_front();
                    if (m_tuser != exp_res.frame_status) begin
                        $error("frame_status: expected %0h, got %0h",
                               exp_res.frame_status, m_tuser);
                        fails++;
                    end
                    if (m_tdata[3:0] != exp_res.payload_len) begin
                        $error("payload_len: expected %0h, got %0h",
                               exp_res.payload_len, m_tdata[3:0]);
                        fails++;
                    end
                    if (m_tdata[67:4] != exp_res.payload_bytes) begin
                        $error("payload_bytes: expected %0h, got %0h",
                               exp_res.payload_bytes, m_tdata[67:4]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                byte_taken = 1'b1;
                n_bytes++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SYNC_FIRST:  sync_regs.sync_first  = cfg_data;
                    REG_SYNC_SECOND: sync_regs.sync_second = cfg_data;
                    REG_SYNC_THIRD:  sync_regs.sync_third  = cfg_data;
                    default: ;
                endcase
                reg_taken = 1'b1;
                n_regs++;
            end
        end
    end

    // driver: works through the plan, at most one step per cycle
    always @(negedge aclk) begin
        logic       nv, ncv;
        logic [7:0] nd, ncd;
        logic [1:0] nci;
        nv  = s_tvalid;
        nd  = s_tdata;
        ncv = cfg_valid;
        nci = cfg_index;
        ncd = cfg_data;
        if (byte_taken) nv = 1'b0;
        if (reg_taken) ncv = 1'b0;
        byte_taken = 1'b0;
        reg_taken  = 1'b0;
        if (started && !nv && !ncv && stim_q.size() > 0) begin
            case (stim_q[0].kind)
                ACT_BYTE: begin
                    if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                        nd = stim_q[0].value;
                        nv = 1'b1;
                        void'(stim_q.pop_front());
                    end
                end
                ACT_REG: begin
                    nci = stim_q[0].index;
                    ncd = stim_q[0].value;
                    ncv = 1'b1;
                    void'(stim_q.pop_front());
                end
                ACT_SETTLE: begin
                    // hold off until every result is back and the pipe has emptied
                    if (pending_frames.size() != 0) begin
                        settle_cnt = 0;
                    end else if (settle_cnt >= SETTLE_CYCLES) begin
                        settle_cnt = 0;
                        void'(stim_q.pop_front());
                    end else begin
                        settle_cnt++;
                    end
                end
                ACT_CALM: begin
                    calm = stim_q[0].value[0];
                    void'(stim_q.pop_front());
                end
                default: begin
                    hold_req = 1'b1;
                    void'(stim_q.pop_front());
                end
            endcase
        end
        s_tvalid  <= nv;
        s_tdata   <= nd;
        cfg_valid <= ncv;
        cfg_index <= nci;
        cfg_data  <= ncd;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sync_regs = '{sync_first: 8'hff, sync_second: 8'h5a, sync_third: 8'ha5};
        phase      = PH_HUNT1;
        bytes_left = '0;
        frame_len  = '0;
        plan_sync[0] = 8'hff;
        plan_sync[1] = 8'h5a;
        plan_sync[2] = 8'ha5;

        // directed: each header position broken, bad lengths, size extremes
        add_byte(8'h00);
        add_frame(1, 8'd1);
        add_frame(2, 8'd1);
        add_frame(-1, 8'd0);
        add_frame(-1, 8'd255);
        add_ctrl(ACT_BYTE, REG_SYNC_FIRST, 8'hff);
        add_ctrl(ACT_BYTE, REG_SYNC_FIRST, 8'h5a);
        add_ctrl(ACT_BYTE, REG_SYNC_FIRST, 8'ha5);
        add_byte(8'd1);
        add_byte(8'hff);
        add_frame(-1, 8'd9);
        for (int i = 0; i < 3; i++) add_byte(plan_sync[i]);
        add_byte(8'd8);
        for (int i = 0; i < 8; i++) add_byte(i[0] ? 8'hff : 8'h00);

        add_sync(8'h00, 8'hff, 8'h00);
        add_random_traffic(110);

        // receiver stalls while hunting mismatches keep coming
        add_ctrl(ACT_HOLD, REG_SYNC_FIRST, 8'd0);
        for (int i = 0; i < 30; i++) add_byte(8'($urandom_range(1, 255)));
        add_ctrl(ACT_SETTLE, REG_SYNC_FIRST, 8'd0);

        add_sync(8'hff, 8'h00, 8'hff);
        add_ctrl(ACT_REG, REG_SPARE, 8'h3c);
        add_ctrl(ACT_CALM, REG_SYNC_FIRST, 8'd1);
        add_random_traffic(120);
        add_ctrl(ACT_CALM, REG_SYNC_FIRST, 8'd0);

        add_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
        add_random_traffic(110);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        started = 1'b1;

        while (stim_q.size() != 0 || s_tvalid || cfg_valid) @(posedge aclk);
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d bytes and %0d register writes: %0d frames,",
                 n_bytes, n_regs, n_frames);
        $display("%0d header mismatches and %0d bad lengths", n_hdr_errs, n_len_errs);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/scfd_pkg.sv
rtl/scfd_parser.sv
rtl/serial_command_frame_deframer_top.sv
test/tb.sv
